// File: design/bedw_pkg.sv
// shared types and constants for the binary erode/dilate window block
package bedw_pkg;

    // field widths of the configuration registers
    localparam int DIM_W = 11;          // image width and height registers
    localparam int WSZ_W = 3;           // window size register
    localparam int RAD_W = 2;           // window radius, size / 2
    localparam int ROW_W = 10;          // row counters
    localparam int HEIGHT_LIMIT = 1024; // rows per frame saturate here

    // configuration register indexes
    localparam int IDX_W = 3;
    typedef enum logic [IDX_W-1:0] {
        REG_MASK   = 3'd0,
        REG_WSIZE  = 3'd1,
        REG_FG     = 3'd2,
        REG_DILATE = 3'd3,
        REG_WIDTH  = 3'd4,
        REG_HEIGHT = 3'd5
    } t_reg_idx;

    // input beat
    typedef struct packed {
        logic pixel_in;
        logic drain;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic pixel_out;
        logic frame_last;
    } t_out_beat;

endpackage

// File: design/binary_erode_dilate_window.sv
// top level of the streaming binary erode/dilate window
//
// binary erosion or dilation over a square window of up to MAX_WINDOW by
// MAX_WINDOW pixels on a raster-order pixel stream. one pixel beat is taken
// every clock unless stalled; each pixel gives exactly one result beat, delayed
// by r rows plus r pixels where r = size / 2; the result of a frame's last rows
// comes out either as the next frame streams in or on drain beats sent after
// the frame. a drain beat yields a result only when no pixel of a frame is in
// progress. sustained rate is one beat per clock unless stalled: the only
// per-pixel state access is one read-modify-write of the column history line
// store, a single memory with one write and one registered read port, so a
// pixel is read, then merged and window checked into the output register, with
// forwarding between back-to-back accesses to the same column. the line store
// is not cleared after reset; its entries are always written in a frame before
// they are looked at. writing window_size, image_width or image_height restarts
// the frame; other registers take effect at the next result.
module binary_erode_dilate_window #(
    parameter int MAX_WINDOW = 5,
    parameter int MAX_WIDTH  = 1024,
    localparam int MSK_W = MAX_WINDOW * MAX_WINDOW,
    localparam int CFG_W = (MSK_W > bedw_pkg::DIM_W) ? MSK_W : bedw_pkg::DIM_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // pixel input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  bedw_pkg::t_in_beat          i_in_data,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output bedw_pkg::t_out_beat         o_out_data,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [bedw_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]            i_cfg_data
);

    import bedw_pkg::*;

    localparam int LB    = MAX_WINDOW - 1;               // history bits per column
    localparam int CW    = $clog2(MAX_WIDTH);            // column counter width
    localparam int WCL   = $clog2(MAX_WIDTH + 1);
    localparam int WDW   = (WCL > DIM_W) ? WCL : DIM_W;  // effective width value
    localparam int WIW   = $clog2(MSK_W);                // window bit index
    localparam int DBW   = $clog2(LB);                   // history bit select
    localparam int RMAX  = (MAX_WINDOW - 1) / 2;
    localparam int PW    = $clog2(RMAX * MAX_WIDTH + RMAX + 1);

    // configuration registers
    logic [MSK_W-1:0] r_mask;
    logic [WSZ_W-1:0] r_wsize;
    logic             r_fg;
    logic             r_dilate;
    logic [DIM_W-1:0] r_img_w;
    logic [DIM_W-1:0] r_img_h;

    // stream position and result backlog
    logic [CW-1:0]    r_in_col,  n_in_col;
    logic [ROW_W-1:0] r_in_row,  n_in_row;
    logic [CW-1:0]    r_out_col, n_out_col;
    logic [ROW_W-1:0] r_out_row, n_out_row;
    logic [PW-1:0]    r_pending, n_pending;
    logic [MSK_W-1:0] r_win;

    // window check setup, follows the configuration
    logic [MSK_W-1:0] r_win_en,   n_win_en;
    logic [WIW-1:0]   r_ctr_idx,  n_ctr_idx;

    // merge stage
    logic             r_s1_valid;
    logic             r_s1_emit,   n_s1_emit;
    logic             r_s1_drain;
    logic             r_s1_pixel;
    logic [CW-1:0]    r_s1_addr;
    logic             r_s1_border, n_s1_border;
    logic             r_s1_last,   n_s1_last;
    logic [DBW-1:0]   r_s1_d,      n_s1_d;
    logic             r_fwd;
    logic [LB-1:0]    r_fwd_data;

    // output register
    logic             r_out_valid;
    t_out_beat        r_out;

    // effective geometry
    logic [WDW-1:0]   geo_w;
    logic [DIM_W-1:0] geo_h;
    logic [WSZ_W-1:0] geo_s;
    logic [RAD_W-1:0] geo_r;
    logic [PW-1:0]    geo_thr;

    logic             restart;
    logic             in_acc;
    logic             s1_adv;
    logic             px;
    logic [CW-1:0]    rd_addr;
    logic             wr_en;

    logic [LB-1:0]    ram_q;
    logic [LB-1:0]    rd;
    logic [MAX_WINDOW-1:0] col;
    logic [MSK_W-1:0] win_n;
    logic             fg;
    logic             centre;
    logic             fail;
    logic             res_pix;

    // geometry: clamp width, height and size, drop an even size to odd,
    // no window at all when the image is smaller than the window
    always_comb begin
        if (r_img_w == '0) begin
            geo_w = WDW'(1);
        end else if (WDW'(r_img_w) > WDW'(MAX_WIDTH)) begin
            geo_w = WDW'(MAX_WIDTH);
        end else begin
            geo_w = WDW'(r_img_w);
        end
        if (r_img_h == '0) begin
            geo_h = DIM_W'(1);
        end else if (r_img_h > DIM_W'(HEIGHT_LIMIT)) begin
            geo_h = DIM_W'(HEIGHT_LIMIT);
        end else begin
            geo_h = r_img_h;
        end
        if (r_wsize == '0) begin
            geo_s = WSZ_W'(1);
        end else if (r_wsize > WSZ_W'(MAX_WINDOW)) begin
            geo_s = WSZ_W'(MAX_WINDOW);
        end else begin
            geo_s = r_wsize;
        end
        if (!geo_s[0]) begin
            geo_s = geo_s - WSZ_W'(1);
        end
        if (geo_w < WDW'(geo_s) || geo_h < DIM_W'(geo_s)) begin
            geo_r = '0;
        end else begin
            geo_r = geo_s[WSZ_W-1:1];
        end
        // a result leaves once r rows plus r pixels are buffered behind it
        geo_thr = PW'(geo_r) * PW'(geo_w) + PW'(geo_r);
    end

    // enabled window positions; bit k*MAX_WINDOW+j is k pixels back, j rows up
    always_comb begin
        logic [WIW-1:0] r2;
        logic [WIW-1:0] v_idx;
        r2       = WIW'({geo_r, 1'b0});
        v_idx    = '0;
        n_win_en = '0;
        for (int k = 0; k < MAX_WINDOW; k++) begin
            for (int j = 0; j < MAX_WINDOW; j++) begin
                if (WIW'(k) <= r2 && WIW'(j) <= r2) begin
                    v_idx = (r2 - WIW'(k)) * WIW'(geo_s) + (r2 - WIW'(j));
                    n_win_en[k*MAX_WINDOW+j] = r_mask[v_idx];
                end
            end
        end
        // centre sits r pixels back and r rows up
        n_ctr_idx = WIW'(geo_r) * WIW'(MAX_WINDOW + 1);
    end

    // handshakes: the merge stage moves unless its result finds the output full
    assign s1_adv     = r_s1_valid && (!r_s1_emit || !r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_adv;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign restart    = i_cfg_we && (i_cfg_index inside {REG_WSIZE, REG_WIDTH, REG_HEIGHT});

    assign px      = !i_in_data.drain;
    // a pixel reads its own column, a drain reads the column of the result
    assign rd_addr = px ? r_in_col : r_out_col;
    assign wr_en   = s1_adv && !r_s1_drain;

    // accept side: counters, emit decision and per-result flags
    always_comb begin
        logic [WDW-1:0]   col_inc;
        logic [DIM_W-1:0] row_inc;
        logic [WDW-1:0]   ocol_inc;
        logic [DIM_W-1:0] orow_inc;
        logic [DIM_W-1:0] h_left;
        logic             emit_px;
        logic             emit_dr;
        col_inc  = WDW'(r_in_col) + WDW'(1);
        row_inc  = DIM_W'(r_in_row) + DIM_W'(1);
        ocol_inc = WDW'(r_out_col) + WDW'(1);
        orow_inc = DIM_W'(r_out_row) + DIM_W'(1);
        emit_px  = r_pending >= geo_thr;
        emit_dr  = (r_pending != '0) && (r_in_row == '0) && (r_in_col == '0);
        n_s1_emit = px ? emit_px : emit_dr;

        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_pending = r_pending;
        if (px) begin
            if (col_inc >= geo_w) begin
                n_in_col = '0;
                n_in_row = (row_inc < geo_h) ? row_inc[ROW_W-1:0] : '0;
            end else begin
                n_in_col = col_inc[CW-1:0];
            end
            if (!emit_px) begin
                n_pending = r_pending + PW'(1);
            end
        end else if (emit_dr) begin
            n_pending = r_pending - PW'(1);
        end

        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (n_s1_emit) begin
            if (ocol_inc >= geo_w) begin
                n_out_col = '0;
                n_out_row = (orow_inc < geo_h) ? orow_inc[ROW_W-1:0] : '0;
            end else begin
                n_out_col = ocol_inc[CW-1:0];
            end
        end

        // pixels within r of any edge pass through
        n_s1_border = (geo_r == '0)
                   || (DIM_W'(r_out_row) < DIM_W'(geo_r))
                   || (DIM_W'(r_out_row) >= geo_h - DIM_W'(geo_r))
                   || (WDW'(r_out_col) < WDW'(geo_r))
                   || (WDW'(r_out_col) >= geo_w - WDW'(geo_r));
        n_s1_last   = (DIM_W'(r_out_row) == geo_h - DIM_W'(1))
                   && (WDW'(r_out_col) == geo_w - WDW'(1));

        // on a drain the centre is this many rows above the frame's last row
        h_left = geo_h - DIM_W'(1) - DIM_W'(r_out_row);
        n_s1_d = (h_left > DIM_W'(LB - 1)) ? DBW'(LB - 1) : h_left[DBW-1:0];
    end

    // line store: one column history entry per image column
    bedw_ram #(
        .WIDTH (LB),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (r_s1_addr),
        .i_wdata (col[LB-1:0]),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // merge stage: new column history, window shift and window check
    always_comb begin
        rd      = r_fwd ? r_fwd_data : ram_q;
        col     = {rd, r_s1_pixel};
        win_n   = {r_win[MSK_W-MAX_WINDOW-1:0], col};
        fg      = r_fg ^ r_dilate;
        centre  = r_s1_drain ? rd[r_s1_d] : win_n[r_ctr_idx];
        fail    = |(r_win_en & (win_n ^ {MSK_W{fg}}));
        res_pix = (!r_s1_border && (centre == fg) && fail) ? ~fg : centre;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= MSK_W'(511);
            r_wsize     <= WSZ_W'(3);
            r_fg        <= 1'b1;
            r_dilate    <= 1'b0;
            r_img_w     <= DIM_W'(640);
            r_img_h     <= DIM_W'(480);
            r_in_col    <= '0;
            r_in_row    <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_pending   <= '0;
            r_win       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_MASK:   r_mask   <= i_cfg_data[MSK_W-1:0];
                    REG_WSIZE:  r_wsize  <= i_cfg_data[WSZ_W-1:0];
                    REG_FG:     r_fg     <= i_cfg_data[0];
                    REG_DILATE: r_dilate <= i_cfg_data[0];
                    REG_WIDTH:  r_img_w  <= i_cfg_data[DIM_W-1:0];
                    REG_HEIGHT: r_img_h  <= i_cfg_data[DIM_W-1:0];
                    default: ;
                endcase
            end

            // a geometry write wins over a pixel still finishing its merge
            if (restart) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
                r_pending <= '0;
                r_win     <= '0;
            end else begin
                if (in_acc) begin
                    r_in_col  <= n_in_col;
                    r_in_row  <= n_in_row;
                    r_out_col <= n_out_col;
                    r_out_row <= n_out_row;
                    r_pending <= n_pending;
                end
                if (wr_en) begin
                    r_win <= win_n;
                end
            end

            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_adv && r_s1_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_win_en  <= n_win_en;
        r_ctr_idx <= n_ctr_idx;
        if (in_acc) begin
            r_s1_emit   <= n_s1_emit;
            r_s1_drain  <= i_in_data.drain;
            r_s1_pixel  <= i_in_data.pixel_in;
            r_s1_addr   <= rd_addr;
            r_s1_border <= n_s1_border;
            r_s1_last   <= n_s1_last;
            r_s1_d      <= n_s1_d;
            // the write landing on this edge is not yet in the read data
            r_fwd       <= wr_en && (r_s1_addr == rd_addr);
            r_fwd_data  <= col[LB-1:0];
        end
        if (s1_adv && r_s1_emit) begin
            r_out.pixel_out  <= res_pix;
            r_out.frame_last <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // backlog never goes past the window delay
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= geo_thr)
        else $error("result backlog beyond window delay");

    // both column counters stay inside the image
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (WDW'(r_in_col) < geo_w) && (WDW'(r_out_col) < geo_w))
        else $error("column counter outside image");

    // drain results lie on the border, where the stale window is unused
    a_drain_border: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_drain && r_s1_emit) |-> r_s1_border)
        else $error("drain result away from border");

endmodule

// File: design/bedw_ram.sv
// generic simple dual-port ram, one write port and one registered read port
module bedw_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
